// ----- design/pst_pkg.sv -----
`timescale 1ns / 1ps
// Package for the prime sieve table: field widths, request codes, sequencer states
// and the structs passed between the sequencer and the shared adder/compare unit.
// No dependencies.
package pst_pkg;

    // Width of the number fields of a request.
    localparam int NUM_W = 10;
    // Datapath width: one bit more than a number, so a running multiple may pass the top.
    localparam int DP_W  = NUM_W + 1;

    // Request kinds.
    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // The only even prime and the first odd prime.
    localparam int EVEN_PRIME      = 2;
    localparam int FIRST_ODD_PRIME = 3;

    typedef logic [NUM_W-1:0] t_num;
    typedef logic [DP_W-1:0]  t_dp;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_INIT   = 9'b000000010,
        ST_PTEST  = 9'b000000100,
        ST_PREAD  = 9'b000001000,
        ST_MARK   = 9'b000010000,
        ST_PINC   = 9'b000100000,
        ST_SQUARE = 9'b001000000,
        ST_QREAD  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } t_state;

    // Operands for the shared adder/compare unit.
    typedef struct packed {
        t_dp a;
        t_dp b;
    } t_alu_ctl;

    // Sum and whether that sum is at or below the sieve top.
    typedef struct packed {
        t_dp  sum;
        logic le_top;
    } t_alu_res;

endpackage

// ----- design/pst_req_if.sv -----
`timescale 1ns / 1ps
// Request channel of the prime sieve table: valid/ready handshake with the request fields.
// Depends on pst_pkg.
interface pst_req_if;
    import pst_pkg::*;

    logic valid;
    logic ready;
    logic req_type;
    t_num limit;
    t_num query_number;

    modport source (output valid, output req_type, output limit, output query_number,
                    input ready);
    modport sink   (input valid, input req_type, input limit, input query_number,
                    output ready);
endinterface

// ----- design/pst_res_if.sv -----
`timescale 1ns / 1ps
// Result channel of the prime sieve table: valid/ready handshake with the result fields.
// No dependencies.
interface pst_res_if;
    logic valid;
    logic ready;
    logic is_prime;
    logic in_range;

    modport source (output valid, output is_prime, output in_range, input ready);
    modport sink   (input valid, input is_prime, input in_range, output ready);
endinterface

// ----- design/prime_sieve_table.sv -----
`timescale 1ns / 1ps
// Prime sieve table: a query's flag read is registered, then loaded into the output register
// once it has room; only then is the next request taken. A build writes each initial flag
// up to the limit, and for each odd p with p*p <= limit reads p's flag, clears its multiples
// from p*p up if set and advances p, all on one shared adder, then a closing test and output load.
// Synchronous active-low reset clears the control and marks the table as not built; the
// flag memory is not cleared, since a query is only answered from entries a build wrote.
module prime_sieve_table #(
    parameter int MAX_NUMBER = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pst_req_if.sink      i_req,
    pst_res_if.source    o_res
);
    import pst_pkg::*;

    // Address width of the flag memory.
    localparam int AddrW  = $clog2(MAX_NUMBER);
    // Highest number a build can cover: the store's last entry, or the field's maximum.
    localparam int TopMax = (MAX_NUMBER - 1 > (1 << NUM_W) - 1) ?
                            (1 << NUM_W) - 1 : MAX_NUMBER - 1;

    // Sequencer and datapath registers.
    t_state r_state, n_state;
    t_num   r_top, n_top;           // top of the running build
    t_dp    r_k, n_k;               // init index, then the running multiple
    t_dp    r_p, n_p;               // current odd sieving candidate
    t_dp    r_sq, n_sq;             // square of r_p, kept by increments
    logic   r_built, n_built;
    t_num   r_built_limit, n_built_limit;
    logic   r_res_prime, n_res_prime;
    logic   r_res_range, n_res_range;

    // Output register: holds a finished result until the sink takes it.
    logic   r_o_valid, n_o_valid;
    logic   r_o_prime, n_o_prime;
    logic   r_o_range, n_o_range;

    // Flag memory ports.
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic             mem_wdata;
    logic [AddrW-1:0] mem_raddr;
    logic             mem_rdata;

    t_alu_ctl alu_ctl;
    t_alu_res alu_res;
    t_num     clamped_limit;
    logic     out_free;

    pst_alu u_alu (
        .i_ctl (alu_ctl),
        .i_top (r_top),
        .o_res (alu_res)
    );

    pst_ram #(
        .WIDTH (1),
        .DEPTH (MAX_NUMBER)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // A limit beyond the store is saturated to its last entry.
    assign clamped_limit = (i_req.limit > NUM_W'(TopMax)) ? NUM_W'(TopMax) : i_req.limit;

    // The output register can take a new result when it is empty or being emptied.
    assign out_free = !r_o_valid || o_res.ready;

    assign i_req.ready    = (r_state == ST_IDLE);
    assign o_res.valid    = r_o_valid;
    assign o_res.is_prime = r_o_prime;
    assign o_res.in_range = r_o_range;

    always_comb begin
        n_state       = r_state;
        n_top         = r_top;
        n_k           = r_k;
        n_p           = r_p;
        n_sq          = r_sq;
        n_built       = r_built;
        n_built_limit = r_built_limit;
        n_res_prime   = r_res_prime;
        n_res_range   = r_res_range;
        n_o_valid     = r_o_valid && !o_res.ready;
        n_o_prime     = r_o_prime;
        n_o_range     = r_o_range;

        alu_ctl.a = r_k;
        alu_ctl.b = DP_W'(1);
        mem_we    = 1'b0;
        mem_waddr = AddrW'(r_k);
        mem_wdata = 1'b0;
        mem_raddr = AddrW'(i_req.query_number);

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_BUILD) begin
                        // The built limit is recorded up front; no query can run meanwhile.
                        n_top         = clamped_limit;
                        n_built_limit = clamped_limit;
                        n_built       = 1'b1;
                        n_k           = '0;
                        n_state       = ST_INIT;
                    end else if (r_built && (i_req.query_number <= r_built_limit)) begin
                        // The flag read was issued at this edge through mem_raddr.
                        n_state = ST_QREAD;
                    end else begin
                        n_res_prime = 1'b0;
                        n_res_range = 1'b0;
                        n_state     = ST_FINISH;
                    end
                end
            end
            ST_INIT: begin
                // Two is prime, odd numbers from three start as prime, all else is not.
                mem_we    = 1'b1;
                mem_wdata = (r_k == DP_W'(EVEN_PRIME)) ||
                            ((r_k >= DP_W'(FIRST_ODD_PRIME)) && r_k[0]);
                n_k       = alu_res.sum;
                if (!alu_res.le_top) begin
                    n_p     = DP_W'(FIRST_ODD_PRIME);
                    n_sq    = DP_W'(FIRST_ODD_PRIME * FIRST_ODD_PRIME);
                    n_state = ST_PTEST;
                end
            end
            ST_PTEST: begin
                // Keep sieving while p*p is within the top; fetch the flag of p.
                alu_ctl.a = r_sq;
                alu_ctl.b = '0;
                mem_raddr = AddrW'(r_p);
                if (alu_res.le_top) begin
                    n_state = ST_PREAD;
                end else begin
                    n_res_prime = 1'b0;
                    n_res_range = 1'b1;
                    n_state     = ST_FINISH;
                end
            end
            ST_PREAD: begin
                if (mem_rdata) begin
                    n_k     = r_sq;
                    n_state = ST_MARK;
                end else begin
                    n_state = ST_PINC;
                end
            end
            ST_MARK: begin
                // Clear one multiple of p per cycle, from p*p upward.
                mem_we    = 1'b1;
                mem_wdata = 1'b0;
                alu_ctl.b = r_p;
                n_k       = alu_res.sum;
                if (!alu_res.le_top) begin
                    n_state = ST_PINC;
                end
            end
            ST_PINC: begin
                alu_ctl.a = r_p;
                alu_ctl.b = DP_W'(EVEN_PRIME);
                n_p       = alu_res.sum;
                n_state   = ST_SQUARE;
            end
            ST_SQUARE: begin
                // With p already advanced by two, the new square is the old one plus
                // 4*(p-1); p is odd, so p-1 is p with its low bit cleared.
                alu_ctl.a = r_sq;
                alu_ctl.b = {r_p[DP_W-3:1], 3'b000};
                n_sq      = alu_res.sum;
                n_state   = ST_PTEST;
            end
            ST_QREAD: begin
                n_res_prime = mem_rdata;
                n_res_range = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                // Hand the result to the output register once it has room.
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_prime = r_res_prime;
                    n_o_range = r_res_range;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_built       <= 1'b0;
            r_built_limit <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_built       <= n_built;
            r_built_limit <= n_built_limit;
            r_o_valid     <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_k         <= n_k;
        r_p         <= n_p;
        r_sq        <= n_sq;
        r_res_prime <= n_res_prime;
        r_res_range <= n_res_range;
        r_o_prime   <= n_o_prime;
        r_o_range   <= n_o_range;
    end
endmodule

// ----- design/pst_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module pst_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/pst_alu.sv -----
`timescale 1ns / 1ps
// Shared adder and top compare of the prime sieve table, used by the sequencer's build steps.
// Depends on pst_pkg.
module pst_alu (
    input  pst_pkg::t_alu_ctl i_ctl,
    input  pst_pkg::t_num     i_top,
    output pst_pkg::t_alu_res o_res
);
    import pst_pkg::*;

    t_dp sum;

    assign sum          = i_ctl.a + i_ctl.b;
    assign o_res.sum    = sum;
    assign o_res.le_top = (sum <= {1'b0, i_top});
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for prime_sieve_table: directed and random build and query requests,
// random idling on both channels and two long result hold-offs, checked against a local sieve.
// Depends on pst_pkg, pst_req_if, pst_res_if and the prime_sieve_table design.
module tb;
    import pst_pkg::*;

    // Flag store depth of the instance under test.
    localparam int SIEVE_DEPTH  = 1024;
    // Number of random requests after the directed part.
    localparam int RANDOM_ITEMS = 1800;
    // The last requests and results of the run go without any idling.
    localparam int QUIET_TAIL   = 150;
    // Length of the long result hold-off that backs the block up.
    localparam int LONG_HOLD    = 300;
    // Cycles to wait after the last answer before the verdict.
    localparam int DRAIN_CYCLES = 20;
    // A build of the full table costs the most and most requests far less, so the correct run
    // stays well below this bound.
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic is_prime;
        logic in_range;
    } t_answer;

    // Keeps its own copy of the primality table and of the built limit, works out the
    // answer of every accepted request and compares the answers that come back in order.
    class sieve_checker;
        bit      flags [SIEVE_DEPTH];
        int      top;
        bit      built;
        int      errors;
        t_answer pending_answers [$];

        function new();
            top    = 0;
            built  = 1'b0;
            errors = 0;
        endfunction

        function void take_request(logic kind, t_num lim, t_num qn);
            t_answer want;
            int      clamped;
            int      p;
            int      m;
            if (kind == REQ_BUILD) begin
                clamped = (int'(lim) >= SIEVE_DEPTH) ? SIEVE_DEPTH - 1 : int'(lim);
                // Two is prime, the odd numbers from three start as prime, all else is not.
                for (m = 0; m <= clamped; m++) begin
                    flags[m] = (m == EVEN_PRIME) || (m >= FIRST_ODD_PRIME && (m % 2) == 1);
                end
                // Strike the multiples of every odd prime from its square upward.
                for (p = FIRST_ODD_PRIME; p * p <= clamped; p += 2) begin
                    if (flags[p]) begin
                        for (m = p * p; m <= clamped; m += p) begin
                            flags[m] = 1'b0;
                        end
                    end
                end
                top           = clamped;
                built         = 1'b1;
                want.is_prime = 1'b0;
                want.in_range = 1'b1;
            end else if (built && int'(qn) <= top) begin
                want.is_prime = flags[qn];
                want.in_range = 1'b1;
            end else begin
                want = '0;
            end
            pending_answers.push_back(want);
        endfunction

        function void check_answer(logic is_prime, logic in_range);
            t_answer want;
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual is_prime=%b in_range=%b",
                         $time, is_prime, in_range);
                return;
            end
            want = pending_answers.pop_front();
            if (is_prime !== want.is_prime) begin
                errors++;
                $display("%0t: is_prime mismatch, expected %b, actual %b",
                         $time, want.is_prime, is_prime);
            end
            if (in_range !== want.in_range) begin
                errors++;
                $display("%0t: in_range mismatch, expected %b, actual %b",
                         $time, want.in_range, in_range);
            end
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    bit   sender_idles;

    sieve_checker board = new();

    pst_req_if req_if ();
    pst_res_if res_if ();

    prime_sieve_table #(
        .MAX_NUMBER(SIEVE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a run that stops making progress ends here as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one request and holds it until the block takes it. The task is entered right
    // after a rising edge and returns right after the edge that accepted the request, so
    // the next call drives its values at that same edge and valid stays high between
    // back-to-back requests. While idling is enabled, a random gap with valid low may come first.
    task automatic offer(input logic kind, input t_num lim, input t_num qn);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.limit        <= lim;
        req_if.query_number <= qn;
        do begin
            @(posedge i_clk);
        end while (!(req_if.valid && req_if.ready));
        board.take_request(kind, lim, qn);
    endtask

    // Result side. Answers are sampled at the rising edge, where the values seen are the
    // ones the block held up to the edge. Ready drops low in random bursts,
    // except during the quiet tail. Twice the receiver holds ready low for a long stretch
    // while the sender keeps offering, so a finished answer waits and the request channel
    // backs up behind it.
    initial begin : result_sink
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                board.check_answer(res_if.is_prime, res_if.in_range);
                seen++;
                if (seen == 500 || seen == 1200) begin
                    hold = LONG_HOLD;
                end
            end
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else if (seen < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 5);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin : request_source
        int   idx;
        int   lim;
        t_num qn;
        sender_idles = 1'b1;
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_QUERY;
        req_if.limit        <= '0;
        req_if.query_number <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Queries before any build must come back as not in range.
        offer(REQ_QUERY, t_num'($urandom), t_num'(0));
        offer(REQ_QUERY, t_num'($urandom), t_num'(1023));
        // Limits below two still build a table, with every covered flag cleared.
        offer(REQ_BUILD, t_num'(0), t_num'($urandom));
        offer(REQ_QUERY, t_num'($urandom), t_num'(0));
        offer(REQ_QUERY, t_num'($urandom), t_num'(1));
        offer(REQ_BUILD, t_num'(1), t_num'($urandom));
        offer(REQ_QUERY, t_num'($urandom), t_num'(1));
        offer(REQ_QUERY, t_num'($urandom), t_num'(2));
        // The smallest limit that covers the even prime.
        offer(REQ_BUILD, t_num'(2), t_num'($urandom));
        offer(REQ_QUERY, t_num'($urandom), t_num'(2));
        offer(REQ_QUERY, t_num'($urandom), t_num'(3));
        // The full table, then its edges and a few composites and primes.
        offer(REQ_BUILD, t_num'(1023), t_num'($urandom));
        offer(REQ_QUERY, t_num'($urandom), t_num'(1023));
        offer(REQ_QUERY, t_num'($urandom), t_num'(1021));
        offer(REQ_QUERY, t_num'($urandom), t_num'(0));
        offer(REQ_QUERY, t_num'($urandom), t_num'(1));
        offer(REQ_QUERY, t_num'($urandom), t_num'(4));
        offer(REQ_QUERY, t_num'($urandom), t_num'(9));
        offer(REQ_QUERY, t_num'($urandom), t_num'(512));
        offer(REQ_QUERY, t_num'($urandom), t_num'(997));
        // A smaller rebuild: stale flags above the new limit must not be answered.
        offer(REQ_BUILD, t_num'(10), t_num'($urandom));
        offer(REQ_QUERY, t_num'($urandom), t_num'(11));
        offer(REQ_QUERY, t_num'($urandom), t_num'(7));
        offer(REQ_QUERY, t_num'($urandom), t_num'(10));
        offer(REQ_QUERY, t_num'($urandom), t_num'(9));

        // Random part. Builds are rare and mostly small, since a build costs cycles in
        // proportion to its limit; only about one build in twelve spans the full range.
        // Most queries fall inside the built table, the rest anywhere in the field.
        for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
            sender_idles = (idx < RANDOM_ITEMS - QUIET_TAIL);
            if ($urandom_range(0, 24) == 0) begin
                case ($urandom_range(0, 11))
                    0: begin
                        lim = $urandom_range(0, 1023);
                    end
                    1: begin
                        lim = $urandom_range(0, 3);
                    end
                    default: begin
                        lim = $urandom_range(2, 80);
                    end
                endcase
                offer(REQ_BUILD, t_num'(lim), t_num'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    qn = t_num'($urandom);
                end else begin
                    qn = t_num'($urandom_range(0, board.top));
                end
                offer(REQ_QUERY, t_num'($urandom), qn);
            end
        end
        req_if.valid <= 1'b0;

        while (board.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
